// File: rtl/skt_pkg.sv
// Shared types, constants and helper functions for the scalar Kalman tracker.
`default_nettype none
package skt_pkg;
  localparam int unsigned NumChannelsDef = 3;
  localparam int unsigned NoiseSlots = 3;
  localparam logic signed [31:0] OneQ16 = 32'sd65536;
  localparam logic signed [31:0] ClampQ16 = 32'sd9830400;
  localparam int unsigned DigitBits = 4;
  localparam int unsigned Digits = 32 / DigitBits;

  typedef enum logic [2:0] {
    CFG_PHI  = 3'd0,
    CFG_CTRL = 3'd1,
    CFG_OBS  = 3'd2,
    CFG_PN   = 3'd3,
    CFG_MN   = 3'd4
  } cfg_idx_t;

  typedef enum logic [0:0] {
    CMD_INIT = 1'b0,
    CMD_UPD  = 1'b1
  } cmd_t;

  // multiplier request and response between sequencer and digit-serial multiplier
  typedef struct packed {
    logic               start;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [31:0] q;
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [31:0] q;
  } div_rsp_t;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    begin
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) sat_add = s[32] ? 32'sh80000000 : 32'sh7fffffff;
      else sat_add = s[31:0];
    end
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    begin
      s = {a[31], a} - {b[31], b};
      if (s[32] != s[31]) sat_sub = s[32] ? 32'sh80000000 : 32'sh7fffffff;
      else sat_sub = s[31:0];
    end
  endfunction
endpackage
`default_nettype wire

// File: rtl/skt_mul.sv
// Digit-serial signed Q16.16 multiplier: four multiplier bits per cycle, floor and saturate.
`default_nettype none
module skt_mul
  import skt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mul_req_t req,
  output mul_rsp_t      rsp
);
  localparam int unsigned CntW = $clog2(Digits + 1);

  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic               neg_r, neg_nxt;
  logic [31:0]        mag_a_r, mag_a_nxt;
  logic [31:0]        sh_b_r, sh_b_nxt;
  logic [63:0]        acc_r, acc_nxt;
  logic signed [31:0] q_r, q_nxt;

  logic [31:0] abs_a, abs_b;
  logic [35:0] part;
  logic [63:0] acc_add;
  logic [48:0] hi;
  logic [48:0] hi_up;

  always_comb begin
    abs_a = req.a[31] ? 32'(-req.a) : req.a;
    abs_b = req.b[31] ? 32'(-req.b) : req.b;
    part = mag_a_r * sh_b_r[DigitBits-1:0];
    // accumulate the digit at the top, shift the sum right one digit each step
    acc_add = {acc_r[63:32] + part[31:0], acc_r[31:0]};
    hi = 49'(acc_r >> 16);
    hi_up = 49'((acc_r + 64'd65535) >> 16);
  end

  always_comb begin
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt = neg_r;
    mag_a_nxt = mag_a_r;
    sh_b_nxt = sh_b_r;
    acc_nxt = acc_r;
    q_nxt = q_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt = '0;
      neg_nxt = req.a[31] ^ req.b[31];
      mag_a_nxt = abs_a;
      sh_b_nxt = abs_b;
      acc_nxt = '0;
    end else if (busy_r) begin
      if (cnt_r == CntW'(Digits)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (!neg_r) begin
          q_nxt = (hi > 49'h7fffffff) ? 32'sh7fffffff : hi[31:0];
        end else begin
          q_nxt = (hi_up > 49'h80000000) ? 32'sh80000000 : 32'(-hi_up[31:0]);
        end
      end else begin
        acc_nxt = {part[35:32] + {3'b0, acc_add[63:32] < acc_r[63:32]},
                   acc_add[63:4]} ;
        acc_nxt[63:60] = 4'(({4'b0, acc_r[63:32]} + {4'b0, part[35:0]}) >> 32);
        sh_b_nxt = sh_b_r >> DigitBits;
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    mag_a_r <= mag_a_nxt;
    sh_b_r <= sh_b_nxt;
    acc_r <= acc_nxt;
    q_r <= q_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.q = q_r;

`ifndef ASSERT_OFF
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("multiplier done held");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(busy_r)) else $error("multiplier done without work");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(Digits)) else $error("multiplier count overrun");
`endif
endmodule
`default_nettype wire

// File: rtl/skt_div.sv
// Radix-2 restoring divider for the gain: (num << 16) / den, truncated and saturated.
`default_nettype none
module skt_div
  import skt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  localparam int unsigned Steps = 48;
  localparam int unsigned CntW = $clog2(Steps + 1);

  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic               neg_r, neg_nxt;
  logic               zero_r, zero_nxt;
  logic [47:0]        quo_r, quo_nxt;
  logic [32:0]        rem_r, rem_nxt;
  logic [31:0]        den_r, den_nxt;
  logic signed [31:0] q_r, q_nxt;

  logic [32:0] trial;
  logic [32:0] shifted;

  always_comb begin
    shifted = {rem_r[31:0], quo_r[47]};
    trial = shifted - {1'b0, den_r};
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt = neg_r;
    zero_nxt = zero_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    q_nxt = q_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt = '0;
      neg_nxt = req.num[31] ^ req.den[31];
      zero_nxt = (req.den == '0);
      quo_nxt = {(req.num[31] ? 32'(-req.num) : req.num), 16'b0};
      rem_nxt = '0;
      den_nxt = req.den[31] ? 32'(-req.den) : req.den;
    end else if (busy_r) begin
      if (cnt_r == CntW'(Steps)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (zero_r) q_nxt = '0;
        else if (!neg_r) q_nxt = (quo_r > 48'h7fffffff) ? 32'sh7fffffff : quo_r[31:0];
        else q_nxt = (quo_r > 48'h80000000) ? 32'sh80000000 : 32'(-quo_r[31:0]);
      end else begin
        if (!trial[32]) begin
          rem_nxt = trial;
          quo_nxt = {quo_r[46:0], 1'b1};
        end else begin
          rem_nxt = shifted;
          quo_nxt = {quo_r[46:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    zero_r <= zero_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r <= q_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.q = q_r;

`ifndef ASSERT_OFF
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !zero_r && cnt_r != '0) |-> (rem_r < {1'b0, den_r}))
    else $error("divider remainder out of range");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(Steps)) else $error("divider count overrun");
`endif
endmodule
`default_nettype wire

// File: rtl/scalar_kalman_tracker_core.sv
// Top level: configuration, per-channel state, update sequencer and output register.
// Work: an update runs nine multiplies and one division, an init three multiplies and one
// division, and a word for an out-of-range channel one multiply; each ends by raising out_valid.
// Flow: one word at a time; in_ready returns the cycle after the result is taken.
// Reset (synchronous, rst_n low): registers to their defaults, all channel state to zero.
`default_nettype none
module scalar_kalman_tracker_core
  import skt_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NumChannelsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [47:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_cmd,
  input  wire logic [1:0]         in_channel,
  input  wire logic signed [31:0] in_measured_distance,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_channel,
  output logic signed [31:0]      out_estimate,
  output logic signed [31:0]      out_clamped_distance
);
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_M1   = 9'b000000010,
    S_M2   = 9'b000000100,
    S_M3   = 9'b000001000,
    S_M4   = 9'b000010000,
    S_M5   = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_M6   = 9'b010000000,
    S_M7   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic               wait_r, wait_nxt;
  logic               den_pend_r, den_pend_nxt;
  logic signed [31:0] phi_r, ctrl_r, obs_r;
  logic [47:0]        pn_r, mn_r;
  logic signed [31:0] est_r [NUM_CHANNELS];
  logic signed [31:0] cov_r [NUM_CHANNELS];
  logic               cmd_r;
  logic [1:0]         ch_r;
  logic signed [31:0] z_r, xp_r, pp_r, zh_r, num_r, t_r, k_r;
  logic signed [31:0] xp_nxt, pp_nxt, zh_nxt, num_nxt, t_nxt, k_nxt;
  logic               ov_r, ov_nxt;
  logic [1:0]         ocr_r;
  logic signed [31:0] oest_r, oz_r, oest_nxt;
  logic               wr_state;
  logic signed [31:0] xn, pn;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  div_req_t dreq;
  div_rsp_t drsp;

  logic               ch_ok;
  logic signed [31:0] q_val, r_val, x_old, p_old, z_clamp;

  skt_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
  skt_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_comb begin
    ch_ok = 32'(ch_r) < NUM_CHANNELS;
    q_val = '0;
    r_val = '0;
    if (ch_r < 2'(NoiseSlots)) begin
      q_val = {8'b0, pn_r[16*ch_r +: 16], 8'b0};
      r_val = {8'b0, mn_r[16*ch_r +: 16], 8'b0};
    end
    x_old = '0;
    p_old = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (32'(ch_r) == i) begin
        x_old = est_r[i];
        p_old = cov_r[i];
      end
    end
    z_clamp = (in_measured_distance > ClampQ16) ? ClampQ16 : in_measured_distance;
  end

  assign in_ready = (state_r == S_IDLE) && !ov_r;

  // sequencer: each working state issues one multiply (or the division) per visit and waits for it
  always_comb begin
    state_nxt = state_r;
    wait_nxt = wait_r;
    den_pend_nxt = den_pend_r;
    xp_nxt = xp_r;
    pp_nxt = pp_r;
    zh_nxt = zh_r;
    num_nxt = num_r;
    t_nxt = t_r;
    k_nxt = k_r;
    ov_nxt = ov_r;
    oest_nxt = oest_r;
    wr_state = 1'b0;
    xn = sat_add(xp_r, mrsp.q);
    pn = mrsp.q;
    mreq = '{start: 1'b0, a: '0, b: '0};
    dreq = '{start: 1'b0, num: num_r, den: sat_add(t_r, r_val)};
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          state_nxt = S_M1;
          wait_nxt = 1'b0;
        end
      end
      S_M1: begin
        // prior estimate
        if (!wait_r) begin
          mreq = '{start: 1'b1, a: phi_r, b: (cmd_r == CMD_INIT) ? z_r : x_old};
          wait_nxt = 1'b1;
        end else if (mrsp.done) begin
          xp_nxt = sat_add(mrsp.q, ctrl_r);
          wait_nxt = 1'b0;
          den_pend_nxt = 1'b0;
          if (!ch_ok) begin
            oest_nxt = '0;
            ov_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else if (cmd_r == CMD_INIT) begin
            pp_nxt = OneQ16;
            num_nxt = OneQ16;
            t_nxt = OneQ16;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_M2;
          end
        end
      end
      S_M2: begin
        if (!wait_r) begin
          mreq = '{start: 1'b1, a: obs_r, b: xp_r};
          wait_nxt = 1'b1;
        end else if (mrsp.done) begin
          zh_nxt = mrsp.q;
          wait_nxt = 1'b0;
          state_nxt = S_M3;
        end
      end
      S_M3: begin
        if (!wait_r) begin
          mreq = '{start: 1'b1, a: phi_r, b: p_old};
          wait_nxt = 1'b1;
        end else if (mrsp.done) begin
          t_nxt = mrsp.q;
          wait_nxt = 1'b0;
          state_nxt = S_M4;
        end
      end
      S_M4: begin
        // predicted covariance
        if (!wait_r) begin
          mreq = '{start: 1'b1, a: t_r, b: phi_r};
          wait_nxt = 1'b1;
        end else if (mrsp.done) begin
          pp_nxt = sat_add(mrsp.q, q_val);
          wait_nxt = 1'b0;
          state_nxt = S_M5;
        end
      end
      S_M5: begin
        // num = pp*H; the same product starts (H*pp)*H in the next state
        if (!wait_r) begin
          mreq = '{start: 1'b1, a: pp_r, b: obs_r};
          wait_nxt = 1'b1;
        end else if (mrsp.done) begin
          // pp*H == H*pp, so the same product serves both
          num_nxt = mrsp.q;
          t_nxt = mrsp.q;
          wait_nxt = 1'b0;
          den_pend_nxt = 1'b1;
          state_nxt = S_M6;
        end
      end
      S_DIV: begin
        if (!wait_r) begin
          dreq.start = 1'b1;
          wait_nxt = 1'b1;
        end else if (drsp.done) begin
          k_nxt = drsp.q;
          wait_nxt = 1'b0;
          state_nxt = S_M6;
        end
      end
      S_M6: begin
        // den_pend marks the pending (H*pp)*H product before the division
        if (!wait_r) begin
          if (den_pend_r)
            mreq = '{start: 1'b1, a: t_r, b: obs_r};
          else
            mreq = '{start: 1'b1, a: k_r,
                     b: sat_sub(z_r, (cmd_r == CMD_INIT) ? xp_r : zh_r)};
          wait_nxt = 1'b1;
        end else if (mrsp.done) begin
          wait_nxt = 1'b0;
          if (den_pend_r) begin
            t_nxt = mrsp.q;
            den_pend_nxt = 1'b0;
            state_nxt = S_DIV;
          end else begin
            xp_nxt = xn;
            t_nxt = (cmd_r == CMD_INIT) ? sat_sub(OneQ16, k_r) : '0;
            state_nxt = S_M7;
            zh_nxt = '0;
          end
        end
      end
      S_M7: begin
        // covariance: (1 - K*H)*pp, (1 - K)*pp on init; update needs K*H first (zh flags it done)
        if (!wait_r) begin
          if (cmd_r == CMD_UPD && zh_r == '0 && t_r == '0)
            mreq = '{start: 1'b1, a: k_r, b: obs_r};
          else
            mreq = '{start: 1'b1, a: t_r, b: pp_r};
          wait_nxt = 1'b1;
        end else if (mrsp.done) begin
          wait_nxt = 1'b0;
          if (cmd_r == CMD_UPD && zh_r == '0 && t_r == '0) begin
            t_nxt = sat_sub(OneQ16, mrsp.q);
            zh_nxt = 32'sd1;
          end else begin
            wr_state = 1'b1;
            oest_nxt = xp_r;
            ov_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wait_r <= 1'b0;
      den_pend_r <= 1'b0;
      ov_r <= 1'b0;
      phi_r <= OneQ16;
      ctrl_r <= '0;
      obs_r <= OneQ16;
      pn_r <= '0;
      mn_r <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        est_r[i] <= '0;
        cov_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      wait_r <= wait_nxt;
      den_pend_r <= den_pend_nxt;
      ov_r <= ov_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_PHI:  phi_r <= cfg_data[31:0];
          CFG_CTRL: ctrl_r <= cfg_data[31:0];
          CFG_OBS:  obs_r <= cfg_data[31:0];
          CFG_PN:   pn_r <= cfg_data;
          CFG_MN:   mn_r <= cfg_data;
          default: ;
        endcase
      end
      if (wr_state) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (32'(ch_r) == i) begin
            est_r[i] <= xp_r;
            cov_r[i] <= pn;
          end
        end
      end
    end
    if (in_valid && in_ready) begin
      cmd_r <= in_cmd;
      ch_r <= in_channel;
      z_r <= z_clamp;
      ocr_r <= in_channel;
      oz_r <= z_clamp;
    end
    xp_r <= xp_nxt;
    pp_r <= pp_nxt;
    zh_r <= zh_nxt;
    num_r <= num_nxt;
    t_r <= t_nxt;
    k_r <= k_nxt;
    oest_r <= oest_nxt;
  end

  assign out_valid = ov_r;
  assign out_channel = ocr_r;
  assign out_estimate = oest_r;
  assign out_clamped_distance = oz_r;

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r != S_IDLE)) else $error("result without work");
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (oz_r <= ClampQ16)) else $error("clamp exceeded");
`endif
endmodule
`default_nettype wire

// File: tb/tb_scalar_kalman_tracker_core.sv
// Self-checking testbench for the scalar Kalman tracker core, with its own fixed-point predictor.
module tb_scalar_kalman_tracker_core;
  import skt_pkg::*;

  localparam int NumCh = 3;
  localparam int QuietLimit = 20000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [47:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic in_cmd;
  logic [1:0] in_channel;
  logic signed [31:0] in_measured_distance;
  logic out_valid;
  logic out_ready;
  logic [1:0] out_channel;
  logic signed [31:0] out_estimate;
  logic signed [31:0] out_clamped_distance;

  int errors = 0;
  int quiet = 0;

  scalar_kalman_tracker_core uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd), .in_channel(in_channel),
    .in_measured_distance(in_measured_distance), .out_valid(out_valid),
    .out_ready(out_ready), .out_channel(out_channel), .out_estimate(out_estimate),
    .out_clamped_distance(out_clamped_distance)
  );

  typedef struct {
    logic [1:0] chan;
    logic signed [31:0] est;
    logic signed [31:0] clamped;
  } estimate_t;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("error: %s got %0h want %0h", what, got, want);
    errors++;
  endtask

  // predictor helpers in Q16.16
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return sat32(p >>> 16);
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat32(64'(a) + 64'(b));
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat32(64'(a) - 64'(b));
  endfunction

  function automatic logic signed [31:0] qdiv(input logic signed [31:0] n,
                                              input logic signed [31:0] d);
    logic signed [63:0] w;
    if (d == 0) return 0;
    w = 64'(n) <<< 16;
    return sat32(w / 64'(d));
  endfunction

  class kalman_board;
    logic signed [31:0] phi, ctrl, obs;
    logic [47:0] pnoise, mnoise;
    logic signed [31:0] x_post[NumCh];
    logic signed [31:0] p_post[NumCh];
    estimate_t pending[$];

    function new();
      phi = OneQ16; ctrl = 0; obs = OneQ16; pnoise = 0; mnoise = 0;
      foreach (x_post[i]) begin
        x_post[i] = 0; p_post[i] = 0;
      end
    endfunction

    function void set_reg(input cfg_idx_t idx, input logic [47:0] v);
      case (idx)
        CFG_PHI:  phi = v[31:0];
        CFG_CTRL: ctrl = v[31:0];
        CFG_OBS:  obs = v[31:0];
        CFG_PN:   pnoise = v;
        default:  mnoise = v;
      endcase
    endfunction

    function logic signed [31:0] noise(input logic [47:0] r, input int ch);
      if (ch >= 3) return 0;
      return {8'd0, r[16*ch +: 16], 8'd0};
    endfunction

    function void note_word(input logic cmd, input logic [1:0] ch, input logic signed [31:0] d);
      estimate_t e;
      logic signed [31:0] z, q, r, xp, pp, k, zh, num, den, xn, pn;
      z = (d > ClampQ16) ? ClampQ16 : d;
      e.chan = ch; e.clamped = z; e.est = 0;
      if (ch < NumCh) begin
        q = noise(pnoise, ch);
        r = noise(mnoise, ch);
        if (cmd == CMD_INIT) begin
          xp = qadd(qmul(phi, z), ctrl);
          pp = OneQ16;
          k = qdiv(pp, qadd(pp, r));
          xn = qadd(xp, qmul(k, qsub(z, xp)));
          pn = qmul(qsub(OneQ16, k), pp);
        end else begin
          xp = qadd(qmul(phi, x_post[ch]), ctrl);
          zh = qmul(obs, xp);
          pp = qadd(qmul(qmul(phi, p_post[ch]), phi), q);
          num = qmul(pp, obs);
          den = qadd(qmul(qmul(obs, pp), obs), r);
          k = qdiv(num, den);
          xn = qadd(xp, qmul(k, qsub(z, zh)));
          pn = qmul(qsub(OneQ16, qmul(k, obs)), pp);
        end
        x_post[ch] = xn; p_post[ch] = pn; e.est = xn;
      end
      pending.push_back(e);
    endfunction

    task check_word(input logic [1:0] ch, input logic signed [31:0] est,
                    input logic signed [31:0] cl);
      estimate_t e;
      if (pending.size() == 0) begin
        report("unexpected word, channel", ch, 0);
        return;
      end
      e = pending.pop_front();
      if (ch !== e.chan) report("out_channel", ch, e.chan);
      if (est !== e.est) report("out_estimate", est, e.est);
      if (cl !== e.clamped) report("out_clamped_distance", cl, e.clamped);
    endtask
  endclass

  kalman_board board;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // watchdog: cycles without any accepted word
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QuietLimit) begin
      $display("scalar_kalman_tracker_core: mismatch");
      $finish;
    end
  end

  // result side: random stall per word, check on accept
  initial begin
    int hold;
    out_ready = 0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (hold > 0) begin
        out_ready <= 0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_word(out_channel, out_estimate, out_clamped_distance);
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [47:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    board.set_reg(idx, v);
    @(posedge clk);
  endtask

  // valid stays up after an accept only when the next word follows at once
  task automatic send_word(input logic cmd, input logic [1:0] ch, input logic [31:0] d,
                           input int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; in_cmd <= cmd; in_channel <= ch; in_measured_distance <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_word(cmd, ch, d);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_dist();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      default: return $urandom_range(0, 200 * 65536) - 20 * 65536;
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      default: return $urandom_range(0, 2 * 65536) - 32768;
    endcase
  endfunction

  function automatic logic [47:0] rand_noise();
    if ($urandom_range(0, 4) == 0) return 48'({$urandom(), $urandom()});
    return {16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)),
            16'($urandom_range(0, 1023))};
  endfunction

  function automatic int rand_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
  endfunction

  initial begin
    logic [1:0] ch;
    board = new();
    rst_n = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; in_cmd = 0; in_channel = 0; in_measured_distance = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset settings, update before init, clamp, extremes, bad channel
    send_word(CMD_UPD, 2'd0, 32'd5 << 16, 0);
    send_word(CMD_INIT, 2'd0, 32'h7fffffff, 0);
    send_word(CMD_INIT, 2'd1, 32'h80000000, 3);
    send_word(CMD_INIT, 2'd2, ClampQ16, 0);
    send_word(CMD_UPD, 2'd2, ClampQ16 + 1, 1);
    send_word(CMD_UPD, 2'd3, 32'd40 << 16, 0);
    send_word(CMD_INIT, 2'd3, 32'hffffffff, 0);
    drain();
    write_reg(CFG_PHI, 48'h0000_0001_0000);
    write_reg(CFG_CTRL, 48'h0000_0000_8000);
    write_reg(CFG_OBS, 48'h0000_0000_0000);
    write_reg(CFG_PN, 48'hffff_ffff_ffff);
    write_reg(CFG_MN, 48'hffff_ffff_ffff);
    for (int i = 0; i < 4; i++) send_word(i[0], 2'(i % 3), rand_dist(), 0);
    drain();
    // zero gain denominator with H zero and R zero
    write_reg(CFG_MN, 48'h0);
    write_reg(CFG_PHI, 48'h0000_7fff_ffff);
    write_reg(CFG_CTRL, 48'h0000_8000_0000);
    for (int i = 0; i < 4; i++) send_word(CMD_UPD, 2'(i % 3), rand_dist(), 0);
    drain();
    write_reg(CFG_PHI, 48'h0000_8000_0000);
    write_reg(CFG_OBS, 48'h0000_7fff_ffff);
    write_reg(CFG_CTRL, 48'h0000_7fff_ffff);
    for (int i = 0; i < 4; i++) send_word(i[1], 2'(i % 3), rand_dist(), 1);
    drain();

    // random phases with fresh settings
    for (int ph = 0; ph < 11; ph++) begin
      write_reg(CFG_PHI, {16'd0, rand_coef()});
      write_reg(CFG_CTRL, {16'd0, ($urandom_range(0, 1)) ? rand_coef() : 32'd0});
      write_reg(CFG_OBS, {16'd0, rand_coef()});
      write_reg(CFG_PN, rand_noise());
      write_reg(CFG_MN, rand_noise());
      for (int c = 0; c < NumCh; c++) send_word(CMD_INIT, 2'(c), rand_dist(), rand_gap());
      for (int n = 0; n < 97; n++) begin
        ch = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        send_word(($urandom_range(0, 7) == 0) ? CMD_INIT : CMD_UPD, ch, rand_dist(),
                  rand_gap());
      end
      drain();
    end

    if (errors == 0) $display("scalar_kalman_tracker_core: match");
    else $display("scalar_kalman_tracker_core: mismatch");
    $finish;
  end
endmodule

// File: scalar_kalman_tracker_core.f
rtl/skt_pkg.sv
rtl/skt_mul.sv
rtl/skt_div.sv
rtl/scalar_kalman_tracker_core.sv
tb/tb_scalar_kalman_tracker_core.sv
